/* sv/ctp_pkg.sv */
// Shared constants for the circle tangent point block.
`timescale 1ns / 1ps
package ctp_pkg;

   // Default coordinate width (signed fixed point, fraction bits cancel out)
   localparam int CTP_COORD_WIDTH = 32;

   // Restoring steps retire one bit per stage; two bits give the minimum
   localparam int CTP_MIN_STEPS = 2;

endpackage

/* sv/ctp_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with side payload.
`timescale 1ns / 1ps
module ctp_isqrt #(
   parameter int ROOT_W = 33,
   parameter int PAY_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [PAY_W-1:0]      in_pay,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [PAY_W-1:0]      out_pay
);
   import ctp_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic               vld_ff  [ROOT_W];
   logic [REM_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   logic [RAD_W-1:0]   rad_ff  [ROOT_W];
   logic [PAY_W-1:0]   pay_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic               v_cur;
      logic [REM_W-1:0]   rem_cur;
      logic [ROOT_W-1:0]  root_cur;
      logic [RAD_W-1:0]   rad_cur;
      logic [PAY_W-1:0]   pay_cur;
      logic [REM_W-1:0]   cat;
      logic [REM_W-1:0]   trial;
      logic [REM_W-1:0]   dif;
      logic               ge;

      if (k == 0) begin : g_first
         assign v_cur    = in_valid;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = in_rad;
         assign pay_cur  = in_pay;
      end else begin : g_next
         assign v_cur    = vld_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign pay_cur  = pay_ff[k-1];
      end

      // bring down next two radicand bits, try root*4+1
      assign cat   = {rem_cur[ROOT_W-1:0], rad_cur[RAD_W-1 -: 2]};
      assign trial = {root_cur, 2'b01};
      assign ge    = (cat >= trial);
      assign dif   = cat - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? dif : cat;
            root_ff[k] <= {root_cur[ROOT_W-2:0], ge};
            rad_ff[k]  <= {rad_cur[RAD_W-3:0], 2'b00};
            pay_ff[k]  <= pay_cur;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_pay   = pay_ff[ROOT_W-1];

   if (ROOT_W < CTP_MIN_STEPS) begin : g_bad_width
      $error("ctp_isqrt: root width too small");
   end

endmodule

/* sv/ctp_udiv.sv */
// Pipelined restoring divider, several lanes over one shared divisor.
`timescale 1ns / 1ps
module ctp_udiv #(
   parameter int DEN_W = 66,
   parameter int QUO_W = 31,
   parameter int LANES = 4,
   parameter int PAY_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LANES-1:0][DEN_W-1:0]   in_rem,   // upper numerator bits, below divisor
   input  logic [LANES-1:0][QUO_W-1:0]   in_low,   // lower numerator bits
   input  logic [DEN_W-1:0]              in_den,
   input  logic [PAY_W-1:0]              in_pay,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [LANES-1:0]              out_nz,   // remainder nonzero
   output logic [PAY_W-1:0]              out_pay
);
   import ctp_pkg::*;

   logic                         vld_ff [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]  rem_ff [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]  low_ff [QUO_W];
   logic [DEN_W-1:0]             den_ff [QUO_W];
   logic [PAY_W-1:0]             pay_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic                         v_cur;
      logic [LANES-1:0][DEN_W-1:0]  rem_cur;
      logic [LANES-1:0][QUO_W-1:0]  low_cur;
      logic [DEN_W-1:0]             den_cur;
      logic [PAY_W-1:0]             pay_cur;
      logic [LANES-1:0][DEN_W:0]    t;
      logic [LANES-1:0][DEN_W:0]    d;
      logic [LANES-1:0]             ge;
      logic [LANES-1:0][DEN_W-1:0]  rem_in;
      logic [LANES-1:0][QUO_W-1:0]  low_in;

      if (k == 0) begin : g_first
         assign v_cur   = in_valid;
         assign rem_cur = in_rem;
         assign low_cur = in_low;
         assign den_cur = in_den;
         assign pay_cur = in_pay;
      end else begin : g_next
         assign v_cur   = vld_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign low_cur = low_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign pay_cur = pay_ff[k-1];
      end

      // shift in one numerator bit, subtract when it fits; quotient bit enters low end
      always_comb begin
         for (int j = 0; j < LANES; j++) begin
            t[j]      = {rem_cur[j], low_cur[j][QUO_W-1]};
            d[j]      = t[j] - {1'b0, den_cur};
            ge[j]     = (t[j] >= {1'b0, den_cur});
            rem_in[j] = ge[j] ? d[j][DEN_W-1:0] : t[j][DEN_W-1:0];
            low_in[j] = {low_cur[j][QUO_W-2:0], ge[j]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            den_ff[k] <= den_cur;
            pay_ff[k] <= pay_cur;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         out_nz[j] = |rem_ff[QUO_W-1][j];
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = low_ff[QUO_W-1];
   assign out_pay   = pay_ff[QUO_W-1];

   if (QUO_W < CTP_MIN_STEPS) begin : g_bad_width
      $error("ctp_udiv: quotient width too small");
   end

endmodule

/* sv/circle_tangent_point.sv */
// Top level: tangent point from an external point to a circle, fully pipelined.
// Throughput: one word per cycle; the square root and the divider retire one bit per stage.
// The whole pipe advances whenever the response register is empty or being taken.
// Reset (synchronous, active high) clears every stage valid bit and the response valid.
`timescale 1ns / 1ps
module circle_tangent_point #(
   parameter int COORD_WIDTH = ctp_pkg::CTP_COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pt_x, pt_y, ctr_x, ctr_y, radius, zero pad
   input  logic [((5*COORD_WIDTH-1+7)/8)*8-1:0] req_tdata,
   // want_left
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tangent_x, tangent_y, zero pad
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic rsp_tuser
);
   import ctp_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int XW     = CW + 1;          // offset
   localparam int DDW    = 2 * CW + 2;      // squared distance
   localparam int R2W    = 2 * CW - 2;      // squared radius
   localparam int SW     = CW + 1;          // root
   localparam int QW     = CW - 1;          // quotient magnitude (bounded by radius)
   localparam int UW     = 2 * CW + 3;      // r*d +/- s*perp(d)
   localparam int AUW    = UW - 1;
   localparam int LW     = CW + 1;
   localparam int HW     = AUW - LW;
   localparam int MGW    = CW - 1 + AUW;    // numerator magnitude
   localparam int CSW    = CW + 2;          // coordinate before clamp
   localparam int OUT_DW = ((2 * CW + 7) / 8) * 8;

   localparam logic signed [CSW-1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
   localparam logic signed [CSW-1:0] SAT_LO = {3'b111, {(CW-1){1'b0}}};

   typedef struct packed {
      logic                 left;
      logic                 enclosed;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic [CW-2:0]        r;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic [DDW-1:0]       dd;
   } geo_type;

   typedef struct packed {
      logic                 left;
      logic                 enclosed;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic [3:0]           neg;
   } tail_type;

   localparam int GEO_W  = $bits(geo_type);
   localparam int TAIL_W = $bits(tail_type);

   logic en;

   // pipe advances when the response register is free
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: offsets ----------------
   logic signed [CW-1:0] ox, oy, cx_w, cy_w;
   logic signed [XW-1:0] dx_in, dy_in;
   logic                 v1_ff;
   logic signed [XW-1:0] dx1_ff, dy1_ff;
   logic signed [CW-1:0] cx1_ff, cy1_ff;
   logic [CW-2:0]        r1_ff;
   logic                 l1_ff;

   assign ox    = req_tdata[CW-1:0];
   assign oy    = req_tdata[2*CW-1:CW];
   assign cx_w  = req_tdata[3*CW-1:2*CW];
   assign cy_w  = req_tdata[4*CW-1:3*CW];
   assign dx_in = XW'(ox) - XW'(cx_w);
   assign dy_in = XW'(oy) - XW'(cy_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff <= dx_in;
         dy1_ff <= dy_in;
         cx1_ff <= cx_w;
         cy1_ff <= cy_w;
         r1_ff  <= req_tdata[5*CW-2:4*CW];
         l1_ff  <= req_tuser;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic signed [DDW-1:0] sqx_in, sqy_in;
   logic [R2W-1:0]        r2_in;
   geo_type               g2_in;
   logic                  v2_ff;
   logic [DDW-1:0]        sqx2_ff, sqy2_ff;
   logic [R2W-1:0]        r2_2_ff;
   geo_type               g2_ff;

   assign sqx_in = dx1_ff * dx1_ff;
   assign sqy_in = dy1_ff * dy1_ff;
   assign r2_in  = r1_ff * r1_ff;

   always_comb begin
      g2_in.left     = l1_ff;
      g2_in.enclosed = 1'b0;
      g2_in.cx       = cx1_ff;
      g2_in.cy       = cy1_ff;
      g2_in.r        = r1_ff;
      g2_in.dx       = dx1_ff;
      g2_in.dy       = dy1_ff;
      g2_in.dd       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx2_ff <= sqx_in;
         sqy2_ff <= sqy_in;
         r2_2_ff <= r2_in;
         g2_ff   <= g2_in;
      end
   end

   // ---------------- stage 3: squared distance ----------------
   geo_type        g3_in;
   logic           v3_ff;
   logic [R2W-1:0] r2_3_ff;
   geo_type        g3_ff;

   always_comb begin
      g3_in    = g2_ff;
      g3_in.dd = sqx2_ff + sqy2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_3_ff <= r2_2_ff;
         g3_ff   <= g3_in;
      end
   end

   // ---------------- stage 4: radicand and enclosure test ----------------
   logic [DDW:0]   diff_w;
   geo_type        g4_in;
   logic           v4_ff;
   logic [DDW-1:0] rad4_ff;
   geo_type        g4_ff;

   assign diff_w = {1'b0, g3_ff.dd} - (DDW+1)'(r2_3_ff);

   always_comb begin
      g4_in          = g3_ff;
      g4_in.enclosed = diff_w[DDW] || (diff_w[DDW-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad4_ff <= diff_w[DDW-1:0];
         g4_ff   <= g4_in;
      end
   end

   // ---------------- square root ----------------
   logic             vs_w;
   logic [SW-1:0]    root_w;
   logic [GEO_W-1:0] gs_bits;
   geo_type          gs_w;

   ctp_isqrt #(
      .ROOT_W (SW),
      .PAY_W  (GEO_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_rad    (rad4_ff),
      .in_pay    (g4_ff),
      .out_valid (vs_w),
      .out_root  (root_w),
      .out_pay   (gs_bits)
   );

   assign gs_w = geo_type'(gs_bits);

   // ---------------- stage 5: cross products ----------------
   logic signed [UW-1:0] prx_in, pry_in, sdx_in, sdy_in;
   logic                 v5_ff;
   logic signed [UW-1:0] prx5_ff, pry5_ff, sdx5_ff, sdy5_ff;
   geo_type              g5_ff;

   assign prx_in = $signed({1'b0, gs_w.r}) * gs_w.dx;
   assign pry_in = $signed({1'b0, gs_w.r}) * gs_w.dy;
   assign sdx_in = $signed({1'b0, root_w}) * gs_w.dx;
   assign sdy_in = $signed({1'b0, root_w}) * gs_w.dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= vs_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prx5_ff <= prx_in;
         pry5_ff <= pry_in;
         sdx5_ff <= sdx_in;
         sdy5_ff <= sdy_in;
         g5_ff   <= gs_w;
      end
   end

   // ---------------- stage 6: lane sums (ax, ay, bx, by) ----------------
   logic                 v6_ff;
   logic signed [UW-1:0] u6_ff [4];
   geo_type              g6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u6_ff[0] <= prx5_ff - sdy5_ff;
         u6_ff[1] <= pry5_ff + sdx5_ff;
         u6_ff[2] <= prx5_ff + sdy5_ff;
         u6_ff[3] <= pry5_ff - sdx5_ff;
         g6_ff    <= g5_ff;
      end
   end

   // ---------------- stage 7: sign and magnitude ----------------
   logic signed [UW-1:0] nu_w [4];
   logic                 v7_ff;
   logic [AUW-1:0]       au7_ff [4];
   logic [3:0]           neg7_ff;
   geo_type              g7_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         nu_w[j] = -u6_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            neg7_ff[j] <= u6_ff[j][UW-1];
            au7_ff[j]  <= u6_ff[j][UW-1] ? nu_w[j][AUW-1:0] : u6_ff[j][AUW-1:0];
         end
         g7_ff <= g6_ff;
      end
   end

   // ---------------- stage 8: radius times magnitude, split in halves ----------------
   logic                   v8_ff;
   logic [CW-1+LW-1:0]     pl8_ff [4];
   logic [CW-1+HW-1:0]     ph8_ff [4];
   logic [3:0]             neg8_ff;
   geo_type                g8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            pl8_ff[j] <= g7_ff.r * au7_ff[j][LW-1:0];
            ph8_ff[j] <= g7_ff.r * au7_ff[j][AUW-1:LW];
         end
         neg8_ff <= neg7_ff;
         g8_ff   <= g7_ff;
      end
   end

   // ---------------- stage 9: join partial products ----------------
   logic            v9_ff;
   logic [MGW-1:0]  mag9_ff [4];
   logic [3:0]      neg9_ff;
   geo_type         g9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            mag9_ff[j] <= {ph8_ff[j], {LW{1'b0}}} + MGW'(pl8_ff[j]);
         end
         neg9_ff <= neg8_ff;
         g9_ff   <= g8_ff;
      end
   end

   // ---------------- divide by squared distance ----------------
   logic [3:0][DDW-1:0] div_rem_w;
   logic [3:0][QW-1:0]  div_low_w;
   tail_type            tail_w;
   logic                vd_w;
   logic [3:0][QW-1:0]  quo_w;
   logic [3:0]          nz_w;
   logic [TAIL_W-1:0]   td_bits;
   tail_type            td_w;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         div_rem_w[j] = mag9_ff[j][MGW-1:QW];
         div_low_w[j] = mag9_ff[j][QW-1:0];
      end
      tail_w.left     = g9_ff.left;
      tail_w.enclosed = g9_ff.enclosed;
      tail_w.cx       = g9_ff.cx;
      tail_w.cy       = g9_ff.cy;
      tail_w.neg      = neg9_ff;
   end

   ctp_udiv #(
      .DEN_W (DDW),
      .QUO_W (QW),
      .LANES (4),
      .PAY_W (TAIL_W)
   ) u_udiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_rem    (div_rem_w),
      .in_low    (div_low_w),
      .in_den    (g9_ff.dd),
      .in_pay    (tail_w),
      .out_valid (vd_w),
      .out_quo   (quo_w),
      .out_nz    (nz_w),
      .out_pay   (td_bits)
   );

   assign td_w = tail_type'(td_bits);

   // ---------------- stage 10: floored signed quotient plus center ----------------
   logic signed [CSW-1:0] base_w [4];
   logic signed [CSW-1:0] qx_w   [4];
   logic signed [CSW-1:0] nzx_w  [4];
   logic                  v10_ff;
   logic signed [CSW-1:0] c10_ff [4];
   logic                  l10_ff;
   logic                  in10_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         base_w[j] = (j % 2 == 0) ? CSW'(td_w.cx) : CSW'(td_w.cy);
         qx_w[j]   = $signed({3'b000, quo_w[j]});
         nzx_w[j]  = $signed(CSW'(nz_w[j]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= vd_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            c10_ff[j] <= td_w.neg[j] ? (base_w[j] - qx_w[j] - nzx_w[j])
                                     : (base_w[j] + qx_w[j]);
         end
         l10_ff  <= td_w.left;
         in10_ff <= td_w.enclosed;
      end
   end

   // ---------------- output: pick side, clamp, register ----------------
   logic                  pick_a;
   logic signed [CSW-1:0] sel_x, sel_y, sat_x, sat_y;
   logic                  rsp_valid_ff;
   logic [CW-1:0]         rsp_x_ff, rsp_y_ff;
   logic                  rsp_st_ff;

   always_comb begin
      pick_a = l10_ff ? (c10_ff[0] < c10_ff[2]) : (c10_ff[0] > c10_ff[2]);
      sel_x  = pick_a ? c10_ff[0] : c10_ff[2];
      sel_y  = pick_a ? c10_ff[1] : c10_ff[3];
      sat_x  = sel_x;
      sat_y  = sel_y;
      if (sel_x > SAT_HI) sat_x = SAT_HI;
      if (sel_x < SAT_LO) sat_x = SAT_LO;
      if (sel_y > SAT_HI) sat_y = SAT_HI;
      if (sel_y < SAT_LO) sat_y = SAT_LO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v10_ff;
      end
   end

   // point on or inside the circle returns zero with status set
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_x_ff  <= in10_ff ? '0 : sat_x[CW-1:0];
         rsp_y_ff  <= in10_ff ? '0 : sat_y[CW-1:0];
         rsp_st_ff <= in10_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_st_ff;

   if (CW < 2 * CTP_MIN_STEPS) begin : g_bad_width
      $error("circle_tangent_point: coordinate width too small");
   end

endmodule
